>>> design/uxv_pkg.sv
// Package: shared types, constants and helpers of the UTF-8 / XML character validator.
package uxv_pkg;

    // Failure reason codes carried on the verdict.
    typedef enum logic [2:0] {
        RSN_NONE       = 3'd0,
        RSN_BAD_BYTE   = 3'd1,
        RSN_TRUNCATED  = 3'd2,
        RSN_OVERLONG   = 3'd3,
        RSN_SURROGATE  = 3'd4,
        RSN_ABOVE_MAX  = 3'd5,
        RSN_BAD_CHAR   = 3'd6,
        RSN_EMPTY_NAME = 3'd7
    } reason_t;

    localparam int CODE_W = 21;

    // Sequence lengths of multi-byte forms.
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    localparam logic [CODE_W-1:0] MAX_CODE = 21'h10FFFF;
    localparam logic [CODE_W-1:0] SURR_LO  = 21'h00D800;
    localparam logic [CODE_W-1:0] SURR_HI  = 21'h00DFFF;
    localparam logic [CODE_W-1:0] MIN_LEN2 = 21'h000080;
    localparam logic [CODE_W-1:0] MIN_LEN3 = 21'h000800;
    localparam logic [CODE_W-1:0] MIN_LEN4 = 21'h010000;
    localparam logic [CODE_W-1:0] NONCHAR_FFFE = 21'h00FFFE;
    localparam logic [CODE_W-1:0] NONCHAR_FFFF = 21'h00FFFF;

    // One byte request.
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       empty_string;
    } in_item_t;

    // One verdict.
    typedef struct packed {
        logic       valid_res;
        logic [2:0] fail_reason;
    } res_item_t;

    // Per-string decoder state.
    typedef struct packed {
        logic [1:0]        pend;
        logic [CODE_W-1:0] acc;
        logic [2:0]        seqlen;
        logic              at_first;
        logic              failed;
        reason_t           reason;
    } str_state_t;

    localparam str_state_t ST_CLEAR = '{
        pend:     2'd0,
        acc:      '0,
        seqlen:   3'd0,
        at_first: 1'b1,
        failed:   1'b0,
        reason:   RSN_NONE
    };

    function automatic logic in_range(input logic [CODE_W-1:0] c,
                                      input logic [CODE_W-1:0] lo,
                                      input logic [CODE_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

endpackage

>>> design/uxv_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
interface uxv_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/uxv_char_class.sv
// Module: XML character class check of one completed code point.
module uxv_char_class
    import uxv_pkg::*;
(
    input  logic [CODE_W-1:0] code,
    input  logic              text_mode,
    input  logic              at_first,
    output logic              ok
);

    logic name_start;
    logic name_char;
    logic text_ok;

    always_comb
    begin
        name_start = (code == 21'h5F)
            || in_range(code, 21'h41, 21'h5A)       || in_range(code, 21'h61, 21'h7A)
            || in_range(code, 21'hC0, 21'hD6)       || in_range(code, 21'hD8, 21'hF6)
            || in_range(code, 21'hF8, 21'h2FF)      || in_range(code, 21'h370, 21'h37D)
            || in_range(code, 21'h37F, 21'h1FFF)    || in_range(code, 21'h200C, 21'h200D)
            || in_range(code, 21'h2070, 21'h218F)   || in_range(code, 21'h2C00, 21'h2FEF)
            || in_range(code, 21'h3001, 21'hD7FF)   || in_range(code, 21'hF900, 21'hFDCF)
            || in_range(code, 21'hFDF0, 21'hFFFD)   || in_range(code, 21'h10000, 21'hEFFFF);

        name_char = name_start
            || (code == 21'h2D) || (code == 21'h2E) || in_range(code, 21'h30, 21'h39)
            || (code == 21'hB7) || in_range(code, 21'h300, 21'h36F)
            || in_range(code, 21'h203F, 21'h2040);

        // Drop C0 controls except tab and newline, and the two noncharacters.
        text_ok = !((code < 21'h20) && (code != 21'h09) && (code != 21'h0A))
            && (code != NONCHAR_FFFE) && (code != NONCHAR_FFFF);

        if (text_mode)
            ok = text_ok;
        else if (at_first)
            ok = name_start;
        else
            ok = name_char;
    end

endmodule

>>> design/uxv_step.sv
// Module: one-byte decode step, from current string state to next state and verdict.
module uxv_step
    import uxv_pkg::*;
(
    input  in_item_t   item,
    input  str_state_t cur,
    output str_state_t nxt,
    output logic       has_res,
    output res_item_t  res
);

    str_state_t        base;
    str_state_t        w;
    logic [7:0]        b;
    logic [CODE_W-1:0] acc_next;
    logic [CODE_W-1:0] char_code;
    logic [CODE_W-1:0] min_code;
    logic              char_ok;

    assign b        = item.data_byte;
    assign base     = item.first_byte ? ST_CLEAR : cur;
    assign acc_next = {base.acc[CODE_W-7:0], b[5:0]};
    // Single-byte characters are the byte itself; others come from the accumulator.
    assign char_code = (base.pend == 2'd0) ? {13'd0, b} : acc_next;

    uxv_char_class u_class (
        .code      (char_code),
        .text_mode (item.action),
        .at_first  (base.at_first),
        .ok        (char_ok)
    );

    always_comb
    begin
        priority if (base.seqlen == SEQ_LEN2)
            min_code = MIN_LEN2;
        else if (base.seqlen == SEQ_LEN3)
            min_code = MIN_LEN3;
        else
            min_code = MIN_LEN4;
    end

    always_comb
    begin
        w       = base;
        has_res = 1'b0;
        res     = '0;

        if (!base.failed)
        begin
            if (base.pend == 2'd0)
            begin
                priority if (b[7] == 1'b0)
                begin
                    if (!char_ok)
                    begin
                        w.failed = 1'b1;
                        w.reason = RSN_BAD_CHAR;
                    end
                    w.at_first = 1'b0;
                end
                else if (b[7:5] == 3'b110)
                begin
                    w.seqlen = SEQ_LEN2;
                    w.acc    = {16'd0, b[4:0]};
                    w.pend   = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    w.seqlen = SEQ_LEN3;
                    w.acc    = {17'd0, b[3:0]};
                    w.pend   = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    w.seqlen = SEQ_LEN4;
                    w.acc    = {18'd0, b[2:0]};
                    w.pend   = 2'd3;
                end
                else
                begin
                    w.failed = 1'b1;
                    w.reason = RSN_BAD_BYTE;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                w.failed = 1'b1;
                w.reason = RSN_BAD_BYTE;
            end
            else
            begin
                w.acc  = acc_next;
                w.pend = base.pend - 2'd1;
                if (base.pend == 2'd1)
                begin
                    priority if (acc_next < min_code)
                    begin
                        w.failed = 1'b1;
                        w.reason = RSN_OVERLONG;
                    end
                    else if (in_range(acc_next, SURR_LO, SURR_HI))
                    begin
                        w.failed = 1'b1;
                        w.reason = RSN_SURROGATE;
                    end
                    else if (acc_next > MAX_CODE)
                    begin
                        w.failed = 1'b1;
                        w.reason = RSN_ABOVE_MAX;
                    end
                    else
                    begin
                        if (!char_ok)
                        begin
                            w.failed = 1'b1;
                            w.reason = RSN_BAD_CHAR;
                        end
                        w.at_first = 1'b0;
                    end
                end
            end
        end

        if (item.last_byte)
        begin
            if (!w.failed && (w.pend != 2'd0))
            begin
                w.failed = 1'b1;
                w.reason = RSN_TRUNCATED;
            end
            has_res         = 1'b1;
            res.valid_res   = !w.failed;
            res.fail_reason = w.failed ? w.reason : RSN_NONE;
            w               = ST_CLEAR;
        end

        // Empty string overrides everything else on the request.
        if (item.empty_string)
        begin
            has_res         = 1'b1;
            res.valid_res   = item.action;
            res.fail_reason = item.action ? RSN_NONE : RSN_EMPTY_NAME;
            w               = ST_CLEAR;
        end

        nxt = w;
    end

endmodule

>>> design/utf8_xml_name_text_validator.sv
// Top level: streaming strict UTF-8 decoder with XML name / text character checks.
//
//  channel      role    payload                                          per request
//  -----------  ------  -----------------------------------------------  -------------------
//  char_stream  sink    action, data_byte, first_byte, last_byte,        one string byte
//                       empty_string
//  verdict      source  valid_res, fail_reason                           one per string end
//
// Throughput is one byte per clock: the decode of a byte is a single pass of shifts, masks and
// range compares between the input register and the string state / verdict registers.
// A verdict is loaded into the verdict register when its byte leaves the input register.
// Reset (rst_n low, asynchronous) empties both registers and returns the string state to the
// start-of-string values.
// A stalled verdict holds the input register only while that register carries another verdict;
// bytes that end no string keep flowing.
module utf8_xml_name_text_validator
    import uxv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    uxv_stream_if.sink   char_stream,
    uxv_stream_if.source verdict
);

    // Input register
    logic       s1_valid_reg;
    logic       s1_valid_next;
    in_item_t   s1_item_reg;

    // String state and verdict register
    str_state_t st_reg;
    str_state_t st_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    res_item_t  out_res_reg;

    logic       has_res;
    res_item_t  step_res;
    logic       s1_fire;
    logic       in_take;

    uxv_step u_step (
        .item    (s1_item_reg),
        .cur     (st_reg),
        .nxt     (st_next),
        .has_res (has_res),
        .res     (step_res)
    );

    // Advance the held byte unless it makes a verdict and the verdict slot stays full.
    assign s1_fire = s1_valid_reg && (!has_res || !out_valid_reg || verdict.ready);
    assign char_stream.ready = !s1_valid_reg || s1_fire;
    assign in_take = char_stream.valid && char_stream.ready;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_fire && has_res)
            out_valid_next = 1'b1;
        else if (verdict.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= ST_CLEAR;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
                st_reg <= st_next;
        end
    end

    // Payload registers: load on handshake, no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= char_stream.payload;
        if (s1_fire && has_res)
            out_res_reg <= step_res;
    end

    assign verdict.valid   = out_valid_reg;
    assign verdict.payload = out_res_reg;

    // Any verdict leaves the string state at its start values.
    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && has_res) |=> (st_reg == ST_CLEAR))
        else $error("string state not cleared after a verdict");

    // A stored reason exists exactly when a failure is recorded.
    a_reason_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.failed == (st_reg.reason != RSN_NONE))
        else $error("failure flag and stored reason disagree");

    // Owed continuations are always fewer than the sequence length.
    a_pend_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.pend != 2'd0) |-> (st_reg.seqlen > {1'b0, st_reg.pend}))
        else $error("continuation count exceeds sequence length");

    // Back-pressure only comes from a full pipe behind a stalled verdict.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !char_stream.ready |-> (s1_valid_reg && out_valid_reg && !verdict.ready))
        else $error("input stalled without a stalled verdict");

endmodule

>>> tb/sv/utf8_xml_name_text_validator_tb.sv
// Testbench for the UTF-8 / XML name and text validator: random strings, checked against a predictor.
module utf8_xml_name_text_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uxv_pkg::*;

    // Check kind carried on action.
    localparam bit MODE_NAME = 1'b0;
    localparam bit MODE_TEXT = 1'b1;

    // Cycles with no handshake on either channel before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Requests per pacing phase; four phases make up the random part.
    localparam int PHASE_REQUESTS = 463;

    // Code points that sit on class borders, surrogate and range limits.
    localparam int unsigned BORDER_CODES [0:32] = '{
        32'h09, 32'h0A, 32'h0D, 32'h1F, 32'h20, 32'h7F, 32'h80, 32'hB7, 32'hD7,
        32'h2FF, 32'h300, 32'h36F, 32'h370, 32'h37E, 32'h7FF, 32'h800, 32'h200C,
        32'h203F, 32'h2040, 32'h3000, 32'h3001, 32'hD7FF, 32'hD800, 32'hDFFF,
        32'hFDCF, 32'hFDD0, 32'hFDF0, 32'hFFFD, 32'hFFFE, 32'hFFFF, 32'h10000,
        32'hEFFFF, 32'h10FFFF
    };

    // Predicts verdicts from accepted bytes and holds them until they come out.
    class verdict_board;
        logic [1:0]        owed       = 2'd0;
        logic [CODE_W-1:0] code       = '0;
        logic [2:0]        seq_len    = 3'd0;
        bit                first_char = 1'b1;
        bit                failed     = 1'b0;
        reason_t           why        = RSN_NONE;

        res_item_t expected_verdicts[$];
        int        errors;
        int        verdicts_seen;

        function void clear_string();
            owed       = 2'd0;
            code       = '0;
            seq_len    = 3'd0;
            first_char = 1'b1;
            failed     = 1'b0;
            why        = RSN_NONE;
        endfunction

        // Keep only the first failure of a string.
        function void mark_fail(reason_t r);
            if (!failed)
            begin
                failed = 1'b1;
                why    = r;
            end
        endfunction

        function bit between(logic [CODE_W-1:0] c, int unsigned lo, int unsigned hi);
            return (c >= lo) && (c <= hi);
        endfunction

        function bit name_start(logic [CODE_W-1:0] c);
            return c == 21'h5F || between(c, 'h41, 'h5A) || between(c, 'h61, 'h7A) ||
                   between(c, 'hC0, 'hD6) || between(c, 'hD8, 'hF6) ||
                   between(c, 'hF8, 'h2FF) || between(c, 'h370, 'h37D) ||
                   between(c, 'h37F, 'h1FFF) || between(c, 'h200C, 'h200D) ||
                   between(c, 'h2070, 'h218F) || between(c, 'h2C00, 'h2FEF) ||
                   between(c, 'h3001, 'hD7FF) || between(c, 'hF900, 'hFDCF) ||
                   between(c, 'hFDF0, 'hFFFD) || between(c, 'h10000, 'hEFFFF);
        endfunction

        function bit name_char(logic [CODE_W-1:0] c);
            return name_start(c) || c == 21'h2D || c == 21'h2E || between(c, 'h30, 'h39) ||
                   c == 21'hB7 || between(c, 'h300, 'h36F) || between(c, 'h203F, 'h2040);
        endfunction

        function void finish_char(logic [CODE_W-1:0] c, bit mode);
            bit ok;
            if (mode == MODE_TEXT)
                ok = !(c < 21'h20 && c != 21'h09 && c != 21'h0A) &&
                     c != NONCHAR_FFFE && c != NONCHAR_FFFF;
            else
                ok = first_char ? name_start(c) : name_char(c);
            if (!ok)
                mark_fail(RSN_BAD_CHAR);
            first_char = 1'b0;
        endfunction

        function void decode_byte(logic [7:0] b, bit mode);
            logic [CODE_W-1:0] floor;
            if (owed == 2'd0)
            begin
                if (!b[7])
                    finish_char(CODE_W'(b), mode);
                else if (b[7:5] == 3'b110)
                begin
                    seq_len = SEQ_LEN2;
                    code    = CODE_W'(b[4:0]);
                    owed    = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    seq_len = SEQ_LEN3;
                    code    = CODE_W'(b[3:0]);
                    owed    = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    seq_len = SEQ_LEN4;
                    code    = CODE_W'(b[2:0]);
                    owed    = 2'd3;
                end
                else
                    mark_fail(RSN_BAD_BYTE);
                return;
            end
            if (b[7:6] != 2'b10)
            begin
                mark_fail(RSN_BAD_BYTE);
                return;
            end
            code = {code[CODE_W-7:0], b[5:0]};
            owed = owed - 2'd1;
            if (owed != 2'd0)
                return;
            floor = (seq_len == SEQ_LEN2) ? MIN_LEN2 : (seq_len == SEQ_LEN3) ? MIN_LEN3 : MIN_LEN4;
            if (code < floor)
                mark_fail(RSN_OVERLONG);
            else if (code >= SURR_LO && code <= SURR_HI)
                mark_fail(RSN_SURROGATE);
            else if (code > MAX_CODE)
                mark_fail(RSN_ABOVE_MAX);
            else
                finish_char(code, mode);
        endfunction

        function void note_byte(in_item_t it);
            res_item_t v;
            if (it.empty_string)
            begin
                clear_string();
                v.valid_res   = (it.action == MODE_TEXT);
                v.fail_reason = (it.action == MODE_TEXT) ? RSN_NONE : RSN_EMPTY_NAME;
                expected_verdicts.push_back(v);
                return;
            end
            if (it.first_byte)
                clear_string();
            if (!failed)
                decode_byte(it.data_byte, it.action);
            if (!it.last_byte)
                return;
            if (!failed && owed != 2'd0)
                mark_fail(RSN_TRUNCATED);
            v.valid_res   = !failed;
            v.fail_reason = failed ? why : RSN_NONE;
            expected_verdicts.push_back(v);
            clear_string();
        endfunction

        function void check_verdict(res_item_t got);
            res_item_t want;
            verdicts_seen++;
            if (expected_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t verdict with none expected: valid_res %0d fail_reason %0d",
                         $time, got.valid_res, got.fail_reason);
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.valid_res !== want.valid_res)
            begin
                errors++;
                $display("%0t valid_res mismatch: expected %0d, actual %0d",
                         $time, want.valid_res, got.valid_res);
            end
            if (got.fail_reason !== want.fail_reason)
            begin
                errors++;
                $display("%0t fail_reason mismatch: expected %0d, actual %0d",
                         $time, want.fail_reason, got.fail_reason);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    uxv_stream_if #(.payload_t(in_item_t))  char_if ();
    uxv_stream_if #(.payload_t(res_item_t)) verdict_if ();

    utf8_xml_name_text_validator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_if),
        .verdict     (verdict_if)
    );

    verdict_board board;
    int idle_pct;
    int stall_pct;
    int requests_sent;

    // Free-running clock, 4 ns period.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drive one request: idle at random first, then hold valid until ready is seen at an edge.
    task automatic send_request(input in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            char_if.valid <= 1'b0;
            @(posedge clk);
        end
        char_if.valid   <= 1'b1;
        char_if.payload <= it;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        board.note_byte(it);
        requests_sent++;
    endtask

    // Empty-string request: data and marks are don't-care, so randomize them.
    task automatic send_empty(input bit mode);
        in_item_t it;
        it.action       = mode;
        it.data_byte    = 8'($urandom);
        it.first_byte   = 1'($urandom);
        it.last_byte    = 1'($urandom);
        it.empty_string = 1'b1;
        send_request(it);
    endtask

    // Send the bytes of one string; mixed flips the check kind on some bytes.
    task automatic send_string(input bit mode, input logic [7:0] bytes_q[$],
                               input bit with_first = 1'b1, input bit with_last = 1'b1,
                               input bit mixed = 1'b0);
        in_item_t it;
        for (int i = 0; i < bytes_q.size(); i++)
        begin
            it.action       = mode ^ (mixed && $urandom_range(9) == 0);
            it.data_byte    = bytes_q[i];
            it.first_byte   = with_first && (i == 0);
            it.last_byte    = with_last && (i == bytes_q.size() - 1);
            it.empty_string = 1'b0;
            send_request(it);
        end
    endtask

    // Append one code point in UTF-8 form; n longer than needed makes an overlong form.
    function automatic void encode_char(ref logic [7:0] q[$], input logic [CODE_W-1:0] c,
                                        input int n);
        case (n)
            1: q.push_back(c[7:0]);
            2:
            begin
                q.push_back({3'b110, c[10:6]});
                q.push_back({2'b10, c[5:0]});
            end
            3:
            begin
                q.push_back({4'b1110, c[15:12]});
                q.push_back({2'b10, c[11:6]});
                q.push_back({2'b10, c[5:0]});
            end
            default:
            begin
                q.push_back({5'b11110, c[20:18]});
                q.push_back({2'b10, c[17:12]});
                q.push_back({2'b10, c[11:6]});
                q.push_back({2'b10, c[5:0]});
            end
        endcase
    endfunction

    // Pick a code point, weighted toward name characters so that name strings often pass.
    function automatic void add_random_char(ref logic [7:0] q[$]);
        logic [CODE_W-1:0] c;
        int n;
        int sel;
        n   = 0;
        sel = $urandom_range(99);
        if (sel < 35)
        begin
            case ($urandom_range(5))
                0: c = CODE_W'(8'h41 + $urandom_range(25));
                1: c = CODE_W'(8'h61 + $urandom_range(25));
                2: c = CODE_W'(8'h30 + $urandom_range(9));
                3: c = 21'h5F;
                4: c = $urandom_range(1) ? 21'h2D : 21'h2E;
                default: c = 21'h3A;
            endcase
        end
        else if (sel < 50)
            c = CODE_W'($urandom_range(127));
        else if (sel < 62)
            c = CODE_W'($urandom_range(32'h7FF, 32'h80));
        else if (sel < 74)
            c = CODE_W'($urandom_range(32'hFFFF, 32'h800));
        else if (sel < 82)
            c = CODE_W'($urandom_range(32'h10FFFF, 32'h10000));
        else if (sel < 92)
            c = CODE_W'(BORDER_CODES[$urandom_range($size(BORDER_CODES) - 1)]);
        else if (sel < 96)
        begin
            // beyond U+10FFFF, only reachable in the four-byte form
            c = CODE_W'($urandom_range(32'h1FFFFF, 32'h110000));
            n = 4;
        end
        else
        begin
            n = 2 + $urandom_range(2);
            c = CODE_W'($urandom_range(n == 2 ? 32'h7F : n == 3 ? 32'h7FF : 32'hFFFF));
        end
        if (n == 0)
            n = (c < 21'h80) ? 1 : (c < 21'h800) ? 2 : (c < 21'h10000) ? 3 : 4;
        encode_char(q, c, n);
    endfunction

    // One random unit of stimulus: mostly well-formed strings, some broken, some noise.
    task automatic random_string();
        logic [7:0] q[$];
        in_item_t   it;
        bit         mode;
        bit         with_first;
        bit         with_last;
        int         roll;
        int         flaw;
        int         pos;
        mode = 1'($urandom);
        roll = $urandom_range(99);
        if (roll < 6)
            send_empty(mode);
        else if (roll < 14)
        begin
            // raw noise: every field random, empty flag included
            repeat ($urandom_range(4, 1))
            begin
                it.action       = 1'($urandom);
                it.data_byte    = 8'($urandom);
                it.first_byte   = 1'($urandom);
                it.last_byte    = 1'($urandom);
                it.empty_string = ($urandom_range(7) == 0);
                send_request(it);
            end
        end
        else
        begin
            repeat ($urandom_range(5, 1))
                add_random_char(q);
            with_first = 1'b1;
            with_last  = 1'b1;
            flaw       = $urandom_range(99);
            if (flaw < 8 && q.size() > 1)
                void'(q.pop_back());
            else if (flaw < 16)
            begin
                pos    = $urandom_range(q.size() - 1);
                q[pos] = 8'($urandom);
            end
            else if (flaw < 20)
                with_first = 1'b0;
            else if (flaw < 24)
                with_last = 1'b0;
            send_string(mode, q, with_first, with_last, $urandom_range(9) == 0);
        end
    endtask

    // Receiver: check each verdict taken at an edge, then redraw ready for the next cycle.
    initial
    begin
        verdict_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && verdict_if.valid && verdict_if.ready)
                board.check_verdict(verdict_if.payload);
            verdict_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: give up once neither channel has moved for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((char_if.valid && char_if.ready) || (verdict_if.valid && verdict_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t no handshake for %0d cycles, %0d verdicts still owed",
                 $time, HANG_LIMIT, board.expected_verdicts.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        board         = new;
        idle_pct      = 0;
        stall_pct     = 0;
        requests_sent = 0;
        rst_n           <= 1'b0;
        char_if.valid   <= 1'b0;
        char_if.payload <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty strings in both modes, a plain name, a bad control, a bad lead.
        send_empty(MODE_NAME);
        send_empty(MODE_TEXT);
        send_string(MODE_NAME, '{8'h41});
        send_string(MODE_TEXT, '{8'h00});
        send_string(MODE_TEXT, '{8'hFF});
        // overlong, surrogate, above U+10FFFF, and the U+FFFE noncharacter in text
        send_string(MODE_NAME, '{8'hC0, 8'h80});
        send_string(MODE_TEXT, '{8'hED, 8'hA0, 8'h80});
        send_string(MODE_TEXT, '{8'hF4, 8'h90, 8'h80, 8'h80});
        send_string(MODE_TEXT, '{8'hEF, 8'hBF, 8'hBE});
        // truncation at the last byte, and a bad continuation that wins over truncation
        send_string(MODE_NAME, '{8'hE2, 8'h82});
        send_string(MODE_TEXT, '{8'hC3, 8'h41});
        // abandon a half-done string with a new first mark
        send_string(MODE_NAME, '{8'hC3}, 1'b1, 1'b0);
        send_string(MODE_NAME, '{8'h42});
        // a string that starts without a first mark after a verdict
        send_string(MODE_TEXT, '{8'h41}, 1'b0, 1'b1);

        // Random part over four pacing phases; drain between phases.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 50; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            while (requests_sent < PHASE_REQUESTS * (phase + 1))
                random_string();
            // hold off the sender until every owed verdict is out
            char_if.valid <= 1'b0;
            @(posedge clk);
            while (board.expected_verdicts.size() != 0)
                @(posedge clk);
        end

        // Let any stray output show up before closing.
        repeat (8) @(posedge clk);

        $display("summary: %0d byte requests over four pacing phases, %0d verdicts checked",
                 requests_sent, board.verdicts_seen);
        $display("summary: %0d mismatches", board.errors);
        if (board.errors == 0 && board.expected_verdicts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
